/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion helpers shared by the crossover RTL
// Thin wrappers around concurrent assertions, clocked, reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define SCS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// same-cycle implication
`define SCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/scs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the moving-average crossover block.
// ----------------------------------------------------------------------------
package scs_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SHORT_RESET = 9'd5;
    localparam logic [CFG_DATA_W-1:0] LONG_RESET  = 9'd20;

    // signal codes
    localparam logic signed [1:0] SIG_NONE = 2'sb00;
    localparam logic signed [1:0] SIG_BUY  = 2'sb01;
    localparam logic signed [1:0] SIG_SELL = 2'sb11;

    // short mean versus long mean
    typedef enum logic [1:0] {
        REL_EQUAL = 2'd0,
        REL_ABOVE = 2'd1,
        REL_BELOW = 2'd2
    } t_rel;

    // per-item control carried down the pipe
    typedef struct packed {
        logic add_s;    // short period nonzero
        logic sub_s;    // short window full before this price
        logic mv_s;     // short mean valid after this price
        logic add_l;
        logic sub_l;
        logic mv_l;
        logic armed;    // enough prices seen to emit a cross
    } t_flags;

endpackage

/* rtl/scs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/scs_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// scs_front
// Ring write slot, saturating sample count, tap addresses and stage-1 regs.
// ----------------------------------------------------------------------------
module scs_front #(
    parameter int WINDOW     = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [PRICE_BITS-1:0]         i_price,
    input  logic                          i_restart,
    input  logic [$clog2(WINDOW+1)-1:0]   i_sp,
    input  logic [$clog2(WINDOW+1)-1:0]   i_lp,
    input  logic                          i_rdy2,
    output logic                          o_rdy1,
    output logic                          o_accept,
    output logic [$clog2(WINDOW)-1:0]     o_waddr,
    output logic [$clog2(WINDOW)-1:0]     o_raddr_s,
    output logic [$clog2(WINDOW)-1:0]     o_raddr_l,
    output logic                          o_v1,
    output logic [PRICE_BITS-1:0]         o_price1,
    output scs_pkg::t_flags               o_flags1
);
    import scs_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int PW = $clog2(WINDOW + 1);
    localparam int SW = $clog2(WINDOW + 2);
    localparam int DW = PW + 1;
    localparam logic [SW-1:0] SEEN_MAX = SW'(WINDOW + 1);

    logic [AW-1:0]         r_slot, n_slot;
    logic [SW-1:0]         r_seen, n_seen;
    logic                  r_v1;
    logic [PRICE_BITS-1:0] r_price1;
    t_flags                r_flags1;

    logic [SW-1:0] seen_new, sp_x, lp_x;
    logic [DW-1:0] slot_x, sp_d, lp_d, tap_s, tap_l;
    t_flags        flags;
    logic          accept;

    assign o_rdy1 = !r_v1 || i_rdy2;
    assign accept = i_valid && o_rdy1;

    always_comb begin
        sp_x     = SW'(i_sp);
        lp_x     = SW'(i_lp);
        seen_new = (r_seen < SEEN_MAX) ? r_seen + SW'(1) : r_seen;

        flags.add_s = (i_sp != '0);
        flags.sub_s = flags.add_s && (r_seen >= sp_x);
        flags.mv_s  = flags.add_s && (seen_new >= sp_x);
        flags.add_l = (i_lp != '0);
        flags.sub_l = flags.add_l && (r_seen >= lp_x);
        flags.mv_l  = flags.add_l && (seen_new >= lp_x);
        flags.armed = (seen_new >= lp_x + SW'(1));

        // slot of the price that leaves each window, modulo WINDOW
        slot_x = DW'(r_slot);
        sp_d   = DW'(i_sp);
        lp_d   = DW'(i_lp);
        tap_s  = (slot_x >= sp_d) ? slot_x - sp_d : slot_x + DW'(WINDOW) - sp_d;
        tap_l  = (slot_x >= lp_d) ? slot_x - lp_d : slot_x + DW'(WINDOW) - lp_d;

        n_slot = r_slot;
        n_seen = r_seen;
        if (i_restart) begin
            n_slot = '0;
            n_seen = '0;
        end else if (accept) begin
            n_slot = (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + AW'(1);
            n_seen = seen_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_seen <= '0;
            r_v1   <= 1'b0;
        end else begin
            r_slot <= n_slot;
            r_seen <= n_seen;
            if (o_rdy1) begin
                r_v1 <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_price1 <= i_price;
            r_flags1 <= flags;
        end
    end

    assign o_accept  = accept;
    assign o_waddr   = r_slot;
    assign o_raddr_s = AW'(tap_s);
    assign o_raddr_l = AW'(tap_l);
    assign o_v1      = r_v1;
    assign o_price1  = r_price1;
    assign o_flags1  = r_flags1;

    `SCS_ASSERT_ALWAYS(a_seen_sat, i_clk, i_rst_n, r_seen <= SEEN_MAX,
        "sample count ran past its saturation point")

endmodule

/* rtl/scs_sums.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_sums
// Running window totals: add the new price, drop the one leaving the window.
// ----------------------------------------------------------------------------
module scs_sums #(
    parameter int WINDOW     = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_restart,
    input  logic                                     i_v1,
    input  logic [PRICE_BITS-1:0]                    i_price1,
    input  scs_pkg::t_flags                          i_flags1,
    input  logic [PRICE_BITS-1:0]                    i_old_s,
    input  logic [PRICE_BITS-1:0]                    i_old_l,
    input  logic                                     i_rdy2,
    output logic                                     o_v2,
    output logic [PRICE_BITS+$clog2(WINDOW)-1:0]     o_sn,
    output logic [PRICE_BITS+$clog2(WINDOW)-1:0]     o_ln,
    output scs_pkg::t_flags                          o_flags2
);
    import scs_pkg::*;

    localparam int TW = PRICE_BITS + $clog2(WINDOW);

    logic [TW-1:0] r_short_total, r_long_total;
    logic [TW-1:0] n_short_total, n_long_total;
    logic [TW-1:0] r_sn, r_ln;
    logic          r_v2;
    t_flags        r_flags2;
    logic          adv1;

    assign adv1 = i_v1 && i_rdy2;

    // modular add/sub: the final total always fits
    always_comb begin
        n_short_total = r_short_total;
        n_long_total  = r_long_total;
        if (i_flags1.add_s) begin
            n_short_total = r_short_total + TW'(i_price1)
                          - (i_flags1.sub_s ? TW'(i_old_s) : '0);
        end
        if (i_flags1.add_l) begin
            n_long_total = r_long_total + TW'(i_price1)
                         - (i_flags1.sub_l ? TW'(i_old_l) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_short_total <= '0;
            r_long_total  <= '0;
        end else if (adv1) begin
            r_short_total <= n_short_total;
            r_long_total  <= n_long_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_rdy2) begin
            r_v2 <= i_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_sn     <= i_flags1.mv_s ? n_short_total : '0;
            r_ln     <= i_flags1.mv_l ? n_long_total : '0;
            r_flags2 <= i_flags1;
        end
    end

    assign o_v2     = r_v2;
    assign o_sn     = r_sn;
    assign o_ln     = r_ln;
    assign o_flags2 = r_flags2;

endmodule

/* rtl/scs_cross.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// scs_cross
// Cross-multiplied mean compare, cross detection and the output register.
// ----------------------------------------------------------------------------
module scs_cross #(
    parameter int WINDOW     = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_restart,
    input  logic [$clog2(WINDOW+1)-1:0]          i_sp,
    input  logic [$clog2(WINDOW+1)-1:0]          i_lp,
    input  logic                                 i_v2,
    input  logic [PRICE_BITS+$clog2(WINDOW)-1:0] i_sn,
    input  logic [PRICE_BITS+$clog2(WINDOW)-1:0] i_ln,
    input  scs_pkg::t_flags                      i_flags2,
    input  logic                                 i_stall,
    output logic                                 o_rdy2,
    output logic                                 o_busy,
    output logic                                 o_valid,
    output logic signed [1:0]                    o_signal
);
    import scs_pkg::*;

    localparam int TW = PRICE_BITS + $clog2(WINDOW);
    localparam int PW = $clog2(WINDOW + 1);
    localparam int MW = TW + PW;

    logic [MW-1:0]    r_pa, r_pb;
    logic             r_armed3;
    logic             r_v3, r_vo;
    logic signed [1:0] r_sig;
    t_rel             r_prior;

    logic [PW-1:0]    sd, ld;
    logic             rdy3, rdy_o;
    t_rel             rel;
    logic signed [1:0] sig;

    assign rdy_o  = !r_vo || !i_stall;
    assign rdy3   = !r_v3 || rdy_o;
    assign o_rdy2 = !i_v2 || rdy3;

    // a window short of its period compares as mean 0 over 1
    assign sd = i_flags2.mv_s ? i_sp : PW'(1);
    assign ld = i_flags2.mv_l ? i_lp : PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_v2 && rdy3) begin
            r_pa     <= MW'(i_sn) * MW'(ld);
            r_pb     <= MW'(i_ln) * MW'(sd);
            r_armed3 <= i_flags2.armed;
        end
    end

    always_comb begin
        if (r_pa > r_pb) begin
            rel = REL_ABOVE;
        end else if (r_pa < r_pb) begin
            rel = REL_BELOW;
        end else begin
            rel = REL_EQUAL;
        end

        sig = SIG_NONE;
        if (r_armed3) begin
            priority if (r_prior != REL_ABOVE && rel == REL_ABOVE) begin
                sig = SIG_BUY;
            end else if (r_prior != REL_BELOW && rel == REL_BELOW) begin
                sig = SIG_SELL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3    <= 1'b0;
            r_vo    <= 1'b0;
            r_prior <= REL_EQUAL;
        end else begin
            if (rdy3) begin
                r_v3 <= i_v2;
            end
            if (rdy_o) begin
                r_vo <= r_v3;
            end
            if (i_restart) begin
                r_prior <= REL_EQUAL;
            end else if (r_v3 && rdy_o) begin
                r_prior <= rel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy_o) begin
            r_sig <= sig;
        end
    end

    assign o_busy   = r_v3 || r_vo;
    assign o_valid  = r_vo;
    assign o_signal = r_sig;

    `SCS_ASSERT_IMP(a_buy_rel, i_clk, i_rst_n, r_vo && r_sig == SIG_BUY,
        r_prior == REL_ABOVE, "buy issued while short mean not above long")
    `SCS_ASSERT_IMP(a_sell_rel, i_clk, i_rst_n, r_vo && r_sig == SIG_SELL,
        r_prior == REL_BELOW, "sell issued while short mean not below long")

endmodule

/* rtl/sma_crossover_signal_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_crossover_signal_top
// Moving-average crossover: one price in, one buy/sell/none signal out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_price; a transfer happens when
//   i_valid is high and o_stall is low. Output channel: o_valid / i_stall
//   with o_signal (+1 golden cross, -1 death cross, 0 otherwise).
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; index 0 is the short period, 1 the long period, any other
//   index is ignored. A period write restarts the history. o_cfg_ready is
//   high only while the pipe is empty and no price is offered.
//   o_valid rises once a price has passed the stage-1, totals, compare and
//   output registers. Throughput: one price per cycle while o_stall is
//   low; the ring memory is read at both window taps and written in the
//   same cycle, and the running totals update in a single add/sub.
//   Reset (synchronous, active low) sets periods to 5 and 20 and clears
//   history; the ring memory needs no clearing pass since an entry is read
//   only after it was written. When the receiver stalls, the output holds
//   and pipeline bubbles still fill; o_stall rises once every stage is full.
// ----------------------------------------------------------------------------
module sma_crossover_signal_top #(
    parameter int WINDOW     = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [31:0]                       i_price,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [1:0]                 o_signal,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import scs_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int PW = $clog2(WINDOW + 1);
    localparam int TW = PRICE_BITS + AW;
    localparam int CW = (PW > CFG_DATA_W) ? PW : CFG_DATA_W;
    localparam int XW = (PRICE_BITS > 32) ? PRICE_BITS : 32;

    logic [CFG_DATA_W-1:0] r_short_period, r_long_period;
    logic [CW-1:0]         sp_w, lp_w;
    logic [PW-1:0]         sp, lp;
    logic [XW-1:0]         price_x;
    logic [PRICE_BITS-1:0] price_m;
    logic                  cfg_we, restart;

    logic                  rdy1, rdy2, accept, v1, v2, busy3;
    logic [AW-1:0]         waddr, raddr_s, raddr_l;
    logic [PRICE_BITS-1:0] price1, old_s, old_l;
    t_flags                flags1, flags2;
    logic [TW-1:0]         sn, ln;

    assign price_x = XW'(i_price);
    assign price_m = price_x[PRICE_BITS-1:0];

    // configuration; never in the same cycle as a price transfer
    assign o_cfg_ready = !(i_valid || v1 || v2 || busy3);
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_we && (i_cfg_index == CFG_SHORT || i_cfg_index == CFG_LONG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_period <= SHORT_RESET;
            r_long_period  <= LONG_RESET;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_SHORT: r_short_period <= i_cfg_data;
                CFG_LONG:  r_long_period  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // periods above the ring depth act as the ring depth
    always_comb begin
        sp_w = CW'(r_short_period);
        lp_w = CW'(r_long_period);
        sp   = (sp_w > CW'(WINDOW)) ? PW'(WINDOW) : PW'(sp_w);
        lp   = (lp_w > CW'(WINDOW)) ? PW'(WINDOW) : PW'(lp_w);
    end

    assign o_stall = !rdy1;

    scs_front #(
        .WINDOW     (WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_price   (price_m),
        .i_restart (restart),
        .i_sp      (sp),
        .i_lp      (lp),
        .i_rdy2    (rdy2),
        .o_rdy1    (rdy1),
        .o_accept  (accept),
        .o_waddr   (waddr),
        .o_raddr_s (raddr_s),
        .o_raddr_l (raddr_l),
        .o_v1      (v1),
        .o_price1  (price1),
        .o_flags1  (flags1)
    );

    // two copies of the price ring, one per window tap
    scs_ram #(
        .WIDTH (PRICE_BITS),
        .DEPTH (WINDOW)
    ) u_ring_s (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (waddr),
        .i_wdata (price_m),
        .i_re    (accept),
        .i_raddr (raddr_s),
        .o_rdata (old_s)
    );

    scs_ram #(
        .WIDTH (PRICE_BITS),
        .DEPTH (WINDOW)
    ) u_ring_l (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (waddr),
        .i_wdata (price_m),
        .i_re    (accept),
        .i_raddr (raddr_l),
        .o_rdata (old_l)
    );

    scs_sums #(
        .WINDOW     (WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_sums (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_v1      (v1),
        .i_price1  (price1),
        .i_flags1  (flags1),
        .i_old_s   (old_s),
        .i_old_l   (old_l),
        .i_rdy2    (rdy2),
        .o_v2      (v2),
        .o_sn      (sn),
        .o_ln      (ln),
        .o_flags2  (flags2)
    );

    scs_cross #(
        .WINDOW     (WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_cross (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_sp      (sp),
        .i_lp      (lp),
        .i_v2      (v2),
        .i_sn      (sn),
        .i_ln      (ln),
        .i_flags2  (flags2),
        .i_stall   (i_stall),
        .o_rdy2    (rdy2),
        .o_busy    (busy3),
        .o_valid   (o_valid),
        .o_signal  (o_signal)
    );

endmodule
